### hdl/rhk_pkg.sv
// ----------------------------------------------------------------------------
// rhk_pkg
// shared types, codes and constants of the keyed parameter store
// ----------------------------------------------------------------------------
package rhk_pkg;

    localparam int MAX_ENTRIES_DEF = 32;
    localparam int TABLE_SLOTS_DEF = 64;
    localparam int KEY_CHARS_DEF   = 8;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [7:0]  SLOT_EMPTY = 8'hFF;

    typedef enum logic [1:0] {
        MODE_REGISTER = 2'd0,
        MODE_GET      = 2'd1,
        MODE_SET      = 2'd2,
        MODE_RESET    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_RANGE    = 3'd4
    } t_status;

    // classified request passed from front to back
    typedef struct packed {
        t_mode              mode;
        logic [63:0]        key;
        logic [31:0]        hash;
        logic signed [31:0] value;
        logic signed [31:0] low_bound;
        logic signed [31:0] high_bound;
    } t_req;

endpackage

### hdl/rhk_ram.sv
// ----------------------------------------------------------------------------
// rhk_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module rhk_ram import rhk_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/rhk_front.sv
// ----------------------------------------------------------------------------
// rhk_front
// accepts requests, trims the key and hashes it one byte per cycle
// ----------------------------------------------------------------------------
module rhk_front import rhk_pkg::*; #(
    parameter int KEY_CHARS = KEY_CHARS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_mode,
    input  logic [63:0]        i_key,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_low_bound,
    input  logic signed [31:0] i_high_bound,
    output logic               o_push,
    output t_req               o_req,
    input  logic               i_full
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_HASH = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate     r_state;
    t_req        r_req;
    logic [63:0] r_shift;
    logic [63:0] canon;

    // keep bytes up to the first zero byte and the key length limit
    always_comb begin
        logic alive;
        alive = 1'b1;
        canon = '0;
        for (int i = 0; i < 8; i++) begin
            alive = alive && (i_key[8*i +: 8] != 8'd0) && (i < KEY_CHARS);
            if (alive) begin
                canon[8*i +: 8] = i_key[8*i +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_req.mode       <= t_mode'(i_mode);
                        r_req.key        <= canon;
                        r_req.hash       <= FNV_BASIS;
                        r_req.value      <= i_value;
                        r_req.low_bound  <= i_low_bound;
                        r_req.high_bound <= i_high_bound;
                        r_shift          <= canon;
                        r_state          <= F_HASH;
                    end
                end
                F_HASH: begin
                    if (r_shift[7:0] == 8'd0) begin
                        r_state <= F_PUSH;
                    end else begin
                        r_req.hash <= (r_req.hash ^ {24'd0, r_shift[7:0]}) * FNV_PRIME;
                        r_shift    <= {8'd0, r_shift[63:8]};
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_full;
    assign o_req   = r_req;

endmodule

### hdl/rhk_queue.sv
// ----------------------------------------------------------------------------
// rhk_queue
// two entry request queue between front and back
// ----------------------------------------------------------------------------
module rhk_queue import rhk_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_req o_req
);

    t_req       r_buf [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_buf[r_wptr] <= i_req;
                r_wptr        <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_req   = r_buf[r_rptr];

endmodule

### hdl/rhk_back.sv
// ----------------------------------------------------------------------------
// rhk_back
// probe walk, robin hood insert and entry update, one request at a time
// ----------------------------------------------------------------------------
module rhk_back import rhk_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  t_req               i_req,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_read_value
);

    localparam int SW = $clog2(TABLE_SLOTS);
    localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int KW = 64 + SW;

    typedef enum logic [9:0] {
        B_IDLE    = 10'b0000000001,
        B_LK_SLOT = 10'b0000000010,
        B_LK_ENT  = 10'b0000000100,
        B_LK_CMP  = 10'b0000001000,
        B_DECIDE  = 10'b0000010000,
        B_EXEC    = 10'b0000100000,
        B_PL_SLOT = 10'b0001000000,
        B_PL_ENT  = 10'b0010000000,
        B_PL_CMP  = 10'b0100000000,
        B_RESP    = 10'b1000000000
    } t_bstate;

    t_bstate            r_state;
    logic [SW-1:0]      r_slot;
    logic [SW:0]        r_d;
    logic [SW:0]        r_n;
    logic [EW-1:0]      r_occ;
    logic [EW-1:0]      r_e;
    logic [EW-1:0]      r_carry;
    logic               r_found;
    logic [CW-1:0]      r_count;
    logic [TABLE_SLOTS-1:0] r_valid;
    t_status            r_res_st;
    logic signed [31:0] r_res_val;
    logic               r_oval;
    logic [2:0]         r_ost;
    logic signed [31:0] r_oval_data;

    // slot table
    logic          slot_we;
    logic [7:0]    slot_wdata;
    logic [7:0]    slot_q;
    // entry stores
    logic          ent_we;
    logic          val_we;
    logic [EW-1:0] ent_raddr;
    logic [EW-1:0] val_waddr;
    logic [31:0]   val_wdata;
    logic [KW-1:0] key_q;
    logic [31:0]   value_q;
    logic [95:0]   param_q;

    logic          used;
    logic [SW-1:0] od;
    logic          full_now;
    logic          out_free;
    logic signed [31:0] p_default, p_low, p_high;

    assign used     = r_valid[r_slot] && ({1'b0, slot_q} < 9'(r_count));
    assign od       = r_slot - key_q[64 +: SW];
    assign full_now = (32'(r_count) >= 32'(MAX_ENTRIES)) ||
                      (32'(r_count) >= 32'(TABLE_SLOTS));
    assign out_free = !r_oval || !i_stall;
    assign p_default = $signed(param_q[95:64]);
    assign p_low     = $signed(param_q[63:32]);
    assign p_high    = $signed(param_q[31:0]);

    always_comb begin
        slot_we    = 1'b0;
        slot_wdata = 8'(r_carry);
        ent_we     = (r_state == B_DECIDE) && (i_req.mode == MODE_REGISTER) &&
                     !r_found && !full_now;
        val_we     = 1'b0;
        val_waddr  = r_e;
        val_wdata  = i_req.value;
        ent_raddr  = r_e;
        if (r_state == B_LK_ENT || r_state == B_PL_ENT) begin
            ent_raddr = slot_q[EW-1:0];
        end
        if (r_state == B_PL_ENT && !used) begin
            slot_we = 1'b1;
        end
        if (r_state == B_PL_CMP && ({1'b0, od} < r_d)) begin
            slot_we = 1'b1;
        end
        if (ent_we) begin
            val_we    = 1'b1;
            val_waddr = r_count[EW-1:0];
        end
        if (r_state == B_EXEC && r_found) begin
            if (i_req.mode == MODE_SET) begin
                val_we = !(i_req.value < p_low || i_req.value > p_high);
            end else if (i_req.mode == MODE_RESET) begin
                val_we    = 1'b1;
                val_wdata = p_default;
            end
        end
    end

    rhk_ram #(.WIDTH(8), .DEPTH(TABLE_SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (r_slot),
        .i_wdata (slot_wdata),
        .i_raddr (r_slot),
        .o_rdata (slot_q)
    );

    rhk_ram #(.WIDTH(KW), .DEPTH(MAX_ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (r_count[EW-1:0]),
        .i_wdata ({i_req.hash[SW-1:0], i_req.key}),
        .i_raddr (ent_raddr),
        .o_rdata (key_q)
    );

    rhk_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (value_q)
    );

    rhk_ram #(.WIDTH(96), .DEPTH(MAX_ENTRIES)) u_param_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (r_count[EW-1:0]),
        .i_wdata ({i_req.value, i_req.low_bound, i_req.high_bound}),
        .i_raddr (ent_raddr),
        .o_rdata (param_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_count <= '0;
            r_valid <= '0;
            r_oval  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_oval <= 1'b1;
            end else if (!i_stall) begin
                r_oval <= 1'b0;
            end
            if (slot_we) begin
                r_valid[r_slot] <= 1'b1;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_slot  <= i_req.hash[SW-1:0];
                        r_d     <= '0;
                        r_found <= 1'b0;
                        r_state <= B_LK_SLOT;
                    end
                end
                B_LK_SLOT: r_state <= B_LK_ENT;
                B_LK_ENT: begin
                    if (!used) begin
                        r_state <= B_DECIDE;
                    end else begin
                        r_occ   <= slot_q[EW-1:0];
                        r_state <= B_LK_CMP;
                    end
                end
                B_LK_CMP: begin
                    if ({1'b0, od} < r_d) begin
                        r_state <= B_DECIDE;
                    end else if (key_q[63:0] == i_req.key) begin
                        r_found <= 1'b1;
                        r_e     <= r_occ;
                        r_state <= B_DECIDE;
                    end else if (r_d == (SW + 1)'(TABLE_SLOTS - 1)) begin
                        r_state <= B_DECIDE;
                    end else begin
                        r_slot  <= r_slot + 1'b1;
                        r_d     <= r_d + 1'b1;
                        r_state <= B_LK_SLOT;
                    end
                end
                B_DECIDE: begin
                    r_res_val <= '0;
                    if (i_req.mode == MODE_REGISTER) begin
                        if (r_found) begin
                            r_res_st <= ST_PRESENT;
                            r_state  <= B_RESP;
                        end else if (full_now) begin
                            r_res_st <= ST_FULL;
                            r_state  <= B_RESP;
                        end else begin
                            r_res_st <= ST_OK;
                            r_carry  <= r_count[EW-1:0];
                            r_count  <= r_count + 1'b1;
                            r_slot   <= i_req.hash[SW-1:0];
                            r_d      <= '0;
                            r_n      <= '0;
                            r_state  <= B_PL_SLOT;
                        end
                    end else if (!r_found) begin
                        r_res_st <= ST_NOTFOUND;
                        r_state  <= B_RESP;
                    end else begin
                        r_state <= B_EXEC;
                    end
                end
                B_EXEC: begin
                    r_res_st <= ST_OK;
                    if (i_req.mode == MODE_GET) begin
                        r_res_val <= $signed(value_q);
                    end else if (i_req.mode == MODE_SET && !val_we) begin
                        r_res_st <= ST_RANGE;
                    end
                    r_state <= B_RESP;
                end
                B_PL_SLOT: r_state <= B_PL_ENT;
                B_PL_ENT: begin
                    if (!used) begin
                        r_state <= B_RESP;
                    end else begin
                        r_occ   <= slot_q[EW-1:0];
                        r_state <= B_PL_CMP;
                    end
                end
                B_PL_CMP: begin
                    // richer occupant gives up its slot and is carried on
                    if ({1'b0, od} < r_d) begin
                        r_carry <= r_occ;
                        r_d     <= {1'b0, od} + 1'b1;
                    end else begin
                        r_d <= r_d + 1'b1;
                    end
                    r_slot <= r_slot + 1'b1;
                    r_n    <= r_n + 1'b1;
                    if (r_n == (SW + 1)'(TABLE_SLOTS - 1)) begin
                        r_state <= B_RESP;
                    end else begin
                        r_state <= B_PL_SLOT;
                    end
                end
                B_RESP: begin
                    if (out_free) begin
                        r_ost       <= r_res_st;
                        r_oval_data <= r_res_val;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_pop        = (r_state == B_RESP) && out_free;
    assign o_valid      = r_oval;
    assign o_status     = r_ost;
    assign o_read_value = r_oval_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(MAX_ENTRIES))
        else $error("entry count above capacity");

    a_slots_vs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'($countones(r_valid)) <= 32'(r_count))
        else $error("more occupied slots than entries");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + 1'b1))
        else $error("entry count moved by other than one");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("queue popped while empty");

endmodule

### hdl/robin_hood_keyed_param_store.sv
// ----------------------------------------------------------------------------
// robin_hood_keyed_param_store
// keyed store of bounded signed parameters on a robin hood hash table
// ----------------------------------------------------------------------------
// input channel: i_valid / o_stall with i_mode, i_key, i_value, i_low_bound,
// i_high_bound; a transfer happens when i_valid is high and o_stall low.
// output channel: o_valid / i_stall with o_status and o_read_value, one
// result per request, in request order.
// the front trims the key and runs fnv-1a one byte per cycle through a
// 32x32 multiplier, then hands the request to a two entry queue. the back
// walks the slot table probe by probe (slot ram read, entry ram read,
// compare), and register adds a second walk for the robin hood insert.
// front and back overlap. reset empties the table at once through per-slot
// valid bits; no clearing pass. while the receiver stalls, a finished
// result waits in the output register; the back can still finish one more
// request and the queue and front fill before o_stall holds off new
// transfers.
// ----------------------------------------------------------------------------
module robin_hood_keyed_param_store import rhk_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int KEY_CHARS   = KEY_CHARS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_mode,
    input  logic [63:0]        i_key,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_low_bound,
    input  logic signed [31:0] i_high_bound,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_read_value
);

    logic push, full, pop, empty;
    t_req front_req, head_req;

    rhk_front #(.KEY_CHARS(KEY_CHARS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_key        (i_key),
        .i_value      (i_value),
        .i_low_bound  (i_low_bound),
        .i_high_bound (i_high_bound),
        .o_push       (push),
        .o_req        (front_req),
        .i_full       (full)
    );

    rhk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (front_req),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_req   (head_req)
    );

    rhk_back #(.MAX_ENTRIES(MAX_ENTRIES), .TABLE_SLOTS(TABLE_SLOTS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_req        (head_req),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_read_value (o_read_value)
    );

endmodule

### dv/robin_hood_keyed_param_store_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// robin_hood_keyed_param_store_tb
// checks register, get, set and reset requests against a behavioral store
// model with fnv-1a hashing and robin hood placement, using random gaps,
// long output stalls and a store that runs full
// ----------------------------------------------------------------------------
module robin_hood_keyed_param_store_tb;
    import rhk_pkg::*;

    localparam int ENTRY_DEPTH = MAX_ENTRIES_DEF;
    localparam int NUM_SLOTS   = TABLE_SLOTS_DEF;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        t_mode              mode;
        logic [63:0]        key;
        logic signed [31:0] value;
        logic signed [31:0] low_bound;
        logic signed [31:0] high_bound;
        int                 gap;
        bit                 drain;
    } t_request;

    typedef struct {
        t_status            status;
        logic signed [31:0] read_value;
    } t_answer;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         in_mode;
    logic [63:0]        in_key;
    logic signed [31:0] in_value;
    logic signed [31:0] in_low;
    logic signed [31:0] in_high;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         out_status;
    logic signed [31:0] out_read_value;

    robin_hood_keyed_param_store dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .o_stall      (in_stall),
        .i_mode       (in_mode),
        .i_key        (in_key),
        .i_value      (in_value),
        .i_low_bound  (in_low),
        .i_high_bound (in_high),
        .o_valid      (out_valid),
        .i_stall      (out_stall),
        .o_status     (out_status),
        .o_read_value (out_read_value)
    );

    // store model
    logic [7:0]         slots [NUM_SLOTS];
    logic [63:0]        keys_m [ENTRY_DEPTH];
    logic signed [31:0] vals_m [ENTRY_DEPTH];
    logic signed [31:0] defs_m [ENTRY_DEPTH];
    logic signed [31:0] lows_m [ENTRY_DEPTH];
    logic signed [31:0] highs_m [ENTRY_DEPTH];
    int                 used_count;

    t_request pending_requests [$];
    t_answer  expected_answers [$];
    logic [63:0] known_keys [$];

    int  errors = 0;
    int  answers_seen = 0;
    int  cycles = 0;
    bit  stimulus_done = 0;
    bit  hold_output = 0;
    int  count_by_status [5] = '{default: 0};

    function automatic logic [63:0] trim_key(logic [63:0] k);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < KEY_CHARS_DEF; i++) begin
            if (k[8*i +: 8] == 8'd0) break;
            r[8*i +: 8] = k[8*i +: 8];
        end
        return r;
    endfunction

    function automatic logic [31:0] fnv_of(logic [63:0] k);
        logic [31:0] h;
        h = FNV_BASIS;
        for (int i = 0; i < 8; i++) begin
            if (k[8*i +: 8] == 8'd0) break;
            h = (h ^ {24'd0, k[8*i +: 8]}) * FNV_PRIME;
        end
        return h;
    endfunction

    function automatic int home_of(logic [63:0] k);
        return int'(fnv_of(k) % NUM_SLOTS);
    endfunction

    function automatic int slot_distance(int s, logic [63:0] k);
        return (s + NUM_SLOTS - home_of(k)) % NUM_SLOTS;
    endfunction

    function automatic bit slot_busy(int s);
        return slots[s] != SLOT_EMPTY && slots[s] < used_count;
    endfunction

    function automatic int locate_entry(logic [63:0] k);
        int s;
        s = home_of(k);
        for (int d = 0; d < NUM_SLOTS; d++) begin
            if (!slot_busy(s)) return -1;
            if (slot_distance(s, keys_m[slots[s]]) < d) return -1;
            if (keys_m[slots[s]] == k) return slots[s];
            s = (s + 1) % NUM_SLOTS;
        end
        return -1;
    endfunction

    function automatic void insert_index(int idx);
        int carry, s, d, occ, od;
        carry = idx;
        s = home_of(keys_m[idx]);
        d = 0;
        for (int n = 0; n < NUM_SLOTS; n++) begin
            if (!slot_busy(s)) begin
                slots[s] = carry[7:0];
                return;
            end
            occ = slots[s];
            od = slot_distance(s, keys_m[occ]);
            if (od < d) begin
                slots[s] = carry[7:0];
                carry = occ;
                d = od;
            end
            s = (s + 1) % NUM_SLOTS;
            d++;
        end
    endfunction

    function automatic void clear_store();
        foreach (slots[i]) slots[i] = SLOT_EMPTY;
        used_count = 0;
    endfunction

    function automatic t_answer serve_request(t_request r);
        t_answer a;
        logic [63:0] k;
        int e;
        a.status = ST_OK;
        a.read_value = '0;
        k = trim_key(r.key);
        e = locate_entry(k);
        if (r.mode == MODE_REGISTER) begin
            if (e >= 0) a.status = ST_PRESENT;
            else if (used_count >= ENTRY_DEPTH || used_count >= NUM_SLOTS) a.status = ST_FULL;
            else begin
                keys_m[used_count]  = k;
                vals_m[used_count]  = r.value;
                defs_m[used_count]  = r.value;
                lows_m[used_count]  = r.low_bound;
                highs_m[used_count] = r.high_bound;
                used_count++;
                insert_index(used_count - 1);
            end
        end else if (e < 0) begin
            a.status = ST_NOTFOUND;
        end else if (r.mode == MODE_GET) begin
            a.read_value = vals_m[e];
        end else if (r.mode == MODE_SET) begin
            if (r.value < lows_m[e] || r.value > highs_m[e]) a.status = ST_RANGE;
            else vals_m[e] = r.value;
        end else begin
            vals_m[e] = defs_m[e];
        end
        return a;
    endfunction

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout at %0t, %0d results outstanding", $time,
                     expected_answers.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // driver
    t_request cur;
    int  wait_left = 0;
    bit  have_cur = 0;
    bit  sent = 0;

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 0;
            in_mode  <= '0;
            in_key   <= '0;
            in_value <= '0;
            in_low   <= '0;
            in_high  <= '0;
        end else if (in_valid) begin
            // lower valid at the falling edge after the transfer
            if (sent) begin
                in_valid <= 0;
                sent = 0;
            end
        end else if (!have_cur && pending_requests.size() > 0) begin
            cur = pending_requests.pop_front();
            have_cur = 1;
            wait_left = cur.gap;
        end else if (have_cur) begin
            if (cur.drain && expected_answers.size() > 0) begin
                // hold until all results are back
            end else if (wait_left > 0) begin
                wait_left--;
            end else begin
                in_mode  <= cur.mode;
                in_key   <= cur.key;
                in_value <= cur.value;
                in_low   <= cur.low_bound;
                in_high  <= cur.high_bound;
                in_valid <= 1;
            end
        end
    end

    // transfer accept and prediction at the rising edge
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall && !sent) begin
            expected_answers.push_back(serve_request(cur));
            have_cur = 0;
            sent = 1;
        end
    end

    // receiver stall
    int stall_left = 0;
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 0;
        end else if (hold_output) begin
            out_stall <= 1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1;
        end else if (out_valid && out_stall) begin
            out_stall <= 0;
        end else if (out_valid && !out_stall) begin
            // draw a stall for the next result
            stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            out_stall <= stall_left > 0;
            if (stall_left > 0) stall_left--;
        end
    end

    // monitor
    always @(posedge clk) begin
        t_answer exp_a;
        if (rst_n && out_valid && !out_stall) begin
            answers_seen++;
            if (expected_answers.size() == 0) begin
                errors++;
                $display("%0t: unexpected result status %0d value %0d", $time,
                         out_status, out_read_value);
            end else begin
                exp_a = expected_answers.pop_front();
                count_by_status[exp_a.status]++;
                if (out_status !== exp_a.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_a.status, out_status);
                end
                if (out_read_value !== exp_a.read_value) begin
                    errors++;
                    $display("%0t: read_value expected %0d actual %0d", $time,
                             exp_a.read_value, out_read_value);
                end
            end
        end
    end

    function automatic logic [63:0] random_key();
        logic [63:0] k;
        int len;
        len = $urandom_range(0, 8);
        k = {$urandom, $urandom};
        for (int i = 0; i < 8; i++) begin
            if (i >= len) k[8*i +: 8] = 8'd0;
            else if (k[8*i +: 8] == 8'd0) k[8*i +: 8] = 8'd1;
        end
        // occasionally keep junk after the terminator
        if ($urandom_range(0, 7) == 0) k[63:56] = $urandom;
        return k;
    endfunction

    function automatic logic signed [31:0] random_word();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $signed($urandom_range(0, 20)) - 10;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_request(t_mode m, logic [63:0] k, logic signed [31:0] v,
                               logic signed [31:0] lo, logic signed [31:0] hi,
                               bit drain = 0, bit no_gap = 0);
        t_request r;
        r.mode = m; r.key = k; r.value = v; r.low_bound = lo; r.high_bound = hi;
        r.drain = drain;
        r.gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        pending_requests.push_back(r);
    endtask

    task automatic wait_empty();
        while (pending_requests.size() > 0 || have_cur || in_valid
               || expected_answers.size() > 0)
            @(posedge clk);
    endtask

    task automatic random_phase(int n);
        logic [63:0] k;
        logic signed [31:0] a, b;
        for (int i = 0; i < n; i++) begin
            if (known_keys.size() > 0 && $urandom_range(0, 3) != 0)
                k = known_keys[$urandom_range(0, known_keys.size() - 1)];
            else
                k = random_key();
            a = random_word();
            b = random_word();
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    known_keys.push_back(k);
                    if ($urandom_range(0, 4) != 0 && a > b)
                        add_request(MODE_REGISTER, k, random_word(), b, a);
                    else
                        add_request(MODE_REGISTER, k, random_word(), a, b);
                end
                3, 4:    add_request(MODE_GET, k, random_word(), a, b);
                5, 6, 7: add_request(MODE_SET, k, $urandom_range(0, 1) ? a
                                     : $signed($urandom_range(0, 20)) - 10, a, b);
                default: add_request(MODE_RESET, k, a, a, b);
            endcase
        end
    endtask

    initial begin
        rst_n = 0;
        clear_store();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed part
        add_request(MODE_GET, 64'd0, 0, 0, 0);
        add_request(MODE_REGISTER, 64'd0, 5, -10, 10);
        add_request(MODE_GET, 64'h00ff_0000, 0, 0, 0);
        add_request(MODE_REGISTER, 64'h0000_0000_0000_0061, 7, 0, 100);
        add_request(MODE_REGISTER, 64'hff00_0000_0000_0061, 1, 0, 1);
        add_request(MODE_REGISTER, 64'hffff_ffff_ffff_ffff, 32'sh8000_0000,
                    32'sh8000_0000, 32'sh7fff_ffff);
        add_request(MODE_SET, 64'hffff_ffff_ffff_ffff, 32'sh7fff_ffff, 0, 0);
        add_request(MODE_GET, 64'hffff_ffff_ffff_ffff, 0, 0, 0);
        add_request(MODE_RESET, 64'hffff_ffff_ffff_ffff, 0, 0, 0);
        add_request(MODE_GET, 64'hffff_ffff_ffff_ffff, 0, 0, 0);
        add_request(MODE_SET, 64'h61, 101, 0, 0);
        add_request(MODE_SET, 64'h61, 100, 0, 0);
        add_request(MODE_GET, 64'h61, 0, 0, 0);
        add_request(MODE_REGISTER, 64'h62, 500, 10, -10);
        add_request(MODE_SET, 64'h62, 0, 0, 0);
        add_request(MODE_RESET, 64'h62, 0, 0, 0);
        add_request(MODE_GET, 64'h62, 0, 0, 0);
        add_request(MODE_SET, 64'h63, 0, 0, 0);
        add_request(MODE_RESET, 64'h63, 0, 0, 0);
        for (int i = 0; i < 30; i++)
            add_request(MODE_REGISTER, {$urandom, $urandom} | 64'h0101_0101_0101_0101,
                        i, -1, 1, 0, 1);
        add_request(MODE_GET, 64'h61, 0, 0, 0);
        wait_empty();

        // long receiver hold while the sender keeps offering
        hold_output = 1;
        for (int i = 0; i < 12; i++) add_request(MODE_GET, 64'h61, 0, 0, 0, 0, 1);
        repeat (400) @(posedge clk);
        hold_output = 0;
        wait_empty();

        // random phases on the full store, each closed by a drained get
        for (int p = 0; p < 5; p++) begin
            random_phase(260);
            add_request(MODE_GET, known_keys.size() ? known_keys[0] : 64'd0,
                        0, 0, 0, 1);
            wait_empty();
        end

        stimulus_done = 1;
        repeat (100) @(posedge clk);
        $display("covered %0d results: ok %0d present %0d full %0d notfound %0d range %0d",
                 answers_seen, count_by_status[0], count_by_status[1], count_by_status[2],
                 count_by_status[3], count_by_status[4]);
        if (errors == 0 && expected_answers.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
